>>> hdl/rba_pkg.sv
// Shared types, constants and helper functions for the relay button autorepeat block.
`default_nettype none
package rba_pkg;

   // Timer and setting widths.
   localparam int TMR_W = 10;
   localparam int SET_W = 8;
   localparam int CNT_W = 8;
   localparam int TGL_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [TMR_W-1:0] TMR_MAX = 10'd1023;
   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
   localparam logic [CNT_W-1:0] CNT_FAST = 8'd8;
   localparam logic [CNT_W-1:0] CNT_FASTEST = 8'd32;
   localparam logic [CNT_W-1:0] DELAY_SLOW = 8'd200;
   localparam logic [CNT_W-1:0] DELAY_FAST = 8'd100;
   localparam logic [CNT_W-1:0] DELAY_FASTEST = 8'd75;
   localparam logic [TGL_W-1:0] TOGGLES_DONE = 3'd6;
   localparam logic [SET_W-1:0] BAR_LIT = 8'hff;
   localparam logic [SET_W-1:0] BAR_DARK = 8'h00;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_MAX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IND_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IND_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 3'd6;

   // Outcome of a button pair on one setting.
   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_INC   = 2'd1,
      VERDICT_DEC   = 2'd2,
      VERDICT_LIMIT = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [SET_W-1:0] cap_max;
      logic [SET_W-1:0] cap_min;
      logic [SET_W-1:0] ind_max;
      logic [SET_W-1:0] ind_min;
      logic [TMR_W-1:0] blink_ticks;
      logic [TMR_W-1:0] idle_timeout_ticks;
      logic [TMR_W-1:0] repeat_reset_ticks;
   } cfg_type;

   typedef struct packed {
      logic cap_up;
      logic cap_down;
      logic ind_up;
      logic ind_down;
      logic other_button;
      logic [SET_W-1:0] caps_now;
      logic [SET_W-1:0] inds_now;
      logic rf_absent;
   } tick_type;

   typedef struct packed {
      logic [SET_W-1:0] caps_next;
      logic [SET_W-1:0] inds_next;
      logic relay_write;
      logic [SET_W-1:0] upper_bar;
      logic [SET_W-1:0] lower_bar;
      logic draw;
      logic in_session;
      logic session_end;
   } result_type;

   // Saturating tick timer increment.
   function automatic logic [TMR_W-1:0] tmr_inc(input logic [TMR_W-1:0] t);
      tmr_inc = (t < TMR_MAX) ? t + 1'b1 : TMR_MAX;
   endfunction

   // Decide what one up/down pair does to its setting.
   function automatic verdict_type judge(input logic up, input logic down,
                                         input logic [SET_W-1:0] now,
                                         input logic [SET_W-1:0] lo,
                                         input logic [SET_W-1:0] hi);
      if (up && down) begin
         judge = VERDICT_NONE;
      end else if (up) begin
         judge = (now < hi) ? VERDICT_INC : VERDICT_LIMIT;
      end else if (down) begin
         judge = (now > lo) ? VERDICT_DEC : VERDICT_LIMIT;
      end else begin
         judge = VERDICT_NONE;
      end
   endfunction

   // Apply a verdict to a setting, wrapping at eight bits.
   function automatic logic [SET_W-1:0] apply(input verdict_type v,
                                              input logic [SET_W-1:0] now);
      case (v)
         VERDICT_INC: apply = now + 1'b1;
         VERDICT_DEC: apply = now - 1'b1;
         default:     apply = now;
      endcase
   endfunction

   // Retrigger delay shortens as the repeat count grows.
   function automatic logic [CNT_W-1:0] retrigger(input logic [CNT_W-1:0] count);
      if (count < CNT_FAST) begin
         retrigger = DELAY_SLOW;
      end else if (count < CNT_FASTEST) begin
         retrigger = DELAY_FAST;
      end else begin
         retrigger = DELAY_FASTEST;
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/rba_csr.sv
// Configuration register file for the relay button autorepeat block.
`default_nettype none
module rba_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [rba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rba_pkg::cfg_type                        cfg
);

   rba_pkg::cfg_type cfg_ff;
   rba_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rba_pkg::CSR_CAP_MAX: cfg_in.cap_max = csr_wdata[rba_pkg::SET_W-1:0];
            rba_pkg::CSR_CAP_MIN: cfg_in.cap_min = csr_wdata[rba_pkg::SET_W-1:0];
            rba_pkg::CSR_IND_MAX: cfg_in.ind_max = csr_wdata[rba_pkg::SET_W-1:0];
            rba_pkg::CSR_IND_MIN: cfg_in.ind_min = csr_wdata[rba_pkg::SET_W-1:0];
            rba_pkg::CSR_BLINK:   cfg_in.blink_ticks = csr_wdata[rba_pkg::TMR_W-1:0];
            rba_pkg::CSR_IDLE:    cfg_in.idle_timeout_ticks = csr_wdata[rba_pkg::TMR_W-1:0];
            rba_pkg::CSR_REPEAT:  cfg_in.repeat_reset_ticks = csr_wdata[rba_pkg::TMR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cap_max <= 8'd127;
         cfg_ff.cap_min <= 8'd0;
         cfg_ff.ind_max <= 8'd127;
         cfg_ff.ind_min <= 8'd0;
         cfg_ff.blink_ticks <= 10'd100;
         cfg_ff.idle_timeout_ticks <= 10'd750;
         cfg_ff.repeat_reset_ticks <= 10'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> hdl/rba_core.sv
// Session, autorepeat and blink state with the per-tick next-state logic.
`default_nettype none
module rba_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire rba_pkg::tick_type tick,
   input  wire rba_pkg::cfg_type  cfg,
   output rba_pkg::result_type    result
);

   logic                          active_ff, active_in;
   logic [rba_pkg::TMR_W-1:0]     since_relay_ff, since_relay_in;
   logic [rba_pkg::TMR_W-1:0]     since_step_ff, since_step_in;
   logic [rba_pkg::TMR_W-1:0]     since_toggle_ff, since_toggle_in;
   logic [rba_pkg::CNT_W-1:0]     repeat_count_ff, repeat_count_in;
   logic [rba_pkg::CNT_W-1:0]     step_delay_ff, step_delay_in;
   logic                          blink_on_ff, blink_on_in;
   logic                          upper_blinking_ff, upper_blinking_in;
   logic                          lower_blinking_ff, lower_blinking_in;
   logic [rba_pkg::TGL_W-1:0]     upper_toggles_ff, upper_toggles_in;
   logic [rba_pkg::TGL_W-1:0]     lower_toggles_ff, lower_toggles_in;

   // One tick of the session machine, all in a single pass.
   always_comb begin
      logic any_relay;
      logic stop;
      rba_pkg::verdict_type cap_v;
      rba_pkg::verdict_type ind_v;
      logic [rba_pkg::SET_W-1:0] pattern;

      any_relay = tick.cap_up | tick.cap_down | tick.ind_up | tick.ind_down;
      stop = 1'b0;
      pattern = rba_pkg::BAR_DARK;

      active_in = active_ff;
      since_relay_in = rba_pkg::tmr_inc(since_relay_ff);
      since_step_in = rba_pkg::tmr_inc(since_step_ff);
      since_toggle_in = rba_pkg::tmr_inc(since_toggle_ff);
      repeat_count_in = repeat_count_ff;
      step_delay_in = step_delay_ff;
      blink_on_in = blink_on_ff;
      upper_blinking_in = upper_blinking_ff;
      lower_blinking_in = lower_blinking_ff;
      upper_toggles_in = upper_toggles_ff;
      lower_toggles_in = lower_toggles_ff;

      result.caps_next = tick.caps_now;
      result.inds_next = tick.inds_now;
      result.relay_write = 1'b0;
      result.upper_bar = rba_pkg::BAR_DARK;
      result.lower_bar = rba_pkg::BAR_DARK;
      result.draw = 1'b0;
      result.session_end = 1'b0;

      cap_v = rba_pkg::judge(tick.cap_up, tick.cap_down, tick.caps_now,
                             cfg.cap_min, cfg.cap_max);
      ind_v = rba_pkg::judge(tick.ind_up, tick.ind_down, tick.inds_now,
                             cfg.ind_min, cfg.ind_max);

      // A relay button press opens a session.
      if (!active_in && any_relay) begin
         active_in = 1'b1;
         since_step_in = '0;
         repeat_count_in = '0;
         step_delay_in = '0;
      end

      // Idle timeout or another button closes it.
      if (active_in) begin
         if (any_relay) begin
            since_relay_in = '0;
         end else if (tick.other_button) begin
            stop = 1'b1;
         end
         if (since_relay_in >= cfg.idle_timeout_ticks) begin
            stop = 1'b1;
         end
         if (stop) begin
            active_in = 1'b0;
            result.session_end = 1'b1;
         end
      end

      if (active_in) begin
         // Autorepeat stepping with acceleration.
         if (any_relay) begin
            if (since_step_in >= {2'b00, step_delay_in}) begin
               since_step_in = '0;
               result.caps_next = rba_pkg::apply(cap_v, tick.caps_now);
               result.inds_next = rba_pkg::apply(ind_v, tick.inds_now);
               result.relay_write = 1'b1;
               if (repeat_count_in < rba_pkg::CNT_MAX) begin
                  repeat_count_in = repeat_count_in + 1'b1;
               end
               step_delay_in = rba_pkg::retrigger(repeat_count_in);
            end
         end else begin
            step_delay_in = '0;
            if (repeat_count_in < rba_pkg::CNT_FAST) begin
               repeat_count_in = '0;
            end
            if (since_step_in >= cfg.repeat_reset_ticks) begin
               repeat_count_in = '0;
            end
         end

         // A fresh limit hit restarts the blink phase.
         if (!upper_blinking_in && !lower_blinking_in &&
             (cap_v == rba_pkg::VERDICT_LIMIT || ind_v == rba_pkg::VERDICT_LIMIT)) begin
            since_toggle_in = '0;
            blink_on_in = 1'b1;
         end
         if (cap_v == rba_pkg::VERDICT_INC || cap_v == rba_pkg::VERDICT_DEC) begin
            lower_blinking_in = 1'b0;
         end else if (cap_v == rba_pkg::VERDICT_LIMIT) begin
            lower_blinking_in = 1'b1;
            lower_toggles_in = '0;
         end
         if (ind_v == rba_pkg::VERDICT_INC || ind_v == rba_pkg::VERDICT_DEC) begin
            upper_blinking_in = 1'b0;
         end else if (ind_v == rba_pkg::VERDICT_LIMIT) begin
            upper_blinking_in = 1'b1;
            upper_toggles_in = '0;
         end

         // Bars show the settings unless a limit blink overrides them.
         result.upper_bar = result.inds_next;
         result.lower_bar = result.caps_next;
         if (upper_blinking_in || lower_blinking_in) begin
            pattern = blink_on_in ? rba_pkg::BAR_LIT : rba_pkg::BAR_DARK;
            if (upper_blinking_in) begin
               result.upper_bar = pattern;
            end
            if (lower_blinking_in) begin
               result.lower_bar = pattern;
            end
            if (since_toggle_in >= cfg.blink_ticks) begin
               since_toggle_in = '0;
               if (upper_blinking_in) begin
                  upper_toggles_in = upper_toggles_in + 1'b1;
               end
               if (upper_toggles_in == rba_pkg::TOGGLES_DONE) begin
                  upper_blinking_in = 1'b0;
               end
               if (lower_blinking_in) begin
                  lower_toggles_in = lower_toggles_in + 1'b1;
               end
               if (lower_toggles_in == rba_pkg::TOGGLES_DONE) begin
                  lower_blinking_in = 1'b0;
               end
               blink_on_in = !blink_on_in;
            end
         end
         result.draw = tick.rf_absent;
      end

      result.in_session = active_in;
   end

   // State advances only on an accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         since_relay_ff <= '0;
         since_step_ff <= '0;
         since_toggle_ff <= '0;
         repeat_count_ff <= '0;
         step_delay_ff <= '0;
         blink_on_ff <= 1'b1;
         upper_blinking_ff <= 1'b0;
         lower_blinking_ff <= 1'b0;
         upper_toggles_ff <= '0;
         lower_toggles_ff <= '0;
      end else if (step_en) begin
         active_ff <= active_in;
         since_relay_ff <= since_relay_in;
         since_step_ff <= since_step_in;
         since_toggle_ff <= since_toggle_in;
         repeat_count_ff <= repeat_count_in;
         step_delay_ff <= step_delay_in;
         blink_on_ff <= blink_on_in;
         upper_blinking_ff <= upper_blinking_in;
         lower_blinking_ff <= lower_blinking_in;
         upper_toggles_ff <= upper_toggles_in;
         lower_toggles_ff <= lower_toggles_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/relay_button_autorepeat_blink_top.sv
// Top level: stream handshake, configuration port and result register.
// Latency: a result beat is valid the cycle after its request beat is accepted.
// Throughput: one tick per cycle unless stalled; set by the single-pass state update.
// The result register frees while it is taken, so only a held result stalls requests.
// Reset (synchronous, active high) clears the session state and loads the
// register defaults; no result is pending after reset.
`default_nettype none
module relay_button_autorepeat_blink_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // Fields from bit 0: cap_up, cap_down, ind_up, ind_down, other_button,
   // caps_now[7:0], inds_now[7:0], rf_absent, zero fill.
   input  wire logic [rba_pkg::REQ_DATA_W-1:0]      req_tdata,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0: caps_next[7:0], inds_next[7:0], relay_write,
   // upper_bar[7:0], lower_bar[7:0], draw, in_session, session_end, zero fill.
   output      logic [rba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [rba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rba_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   rba_pkg::cfg_type    cfg;
   rba_pkg::tick_type   tick;
   rba_pkg::result_type result;
   logic                accept;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [rba_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Unpack the request beat.
   always_comb begin
      tick.cap_up = req_tdata[0];
      tick.cap_down = req_tdata[1];
      tick.ind_up = req_tdata[2];
      tick.ind_down = req_tdata[3];
      tick.other_button = req_tdata[4];
      tick.caps_now = req_tdata[12:5];
      tick.inds_now = req_tdata[20:13];
      tick.rf_absent = req_tdata[21];
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   rba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rba_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .tick    (tick),
      .cfg     (cfg),
      .result  (result)
   );

   // Result register: load on accept, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {4'b0000, result.session_end, result.in_session, result.draw,
                        result.lower_bar, result.upper_bar, result.relay_write,
                        result.inds_next, result.caps_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire
